>>> rtl/core/twol_pkg.sv
`timescale 1ns / 1ps
package twol_pkg;

    localparam int TILE_W     = 8;
    localparam int WIDTH_W    = 8;
    localparam int HEIGHT_W   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOID_CODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_CODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_CODE  = 3'd4;

    typedef struct packed {
        logic [TILE_W-1:0] tile_in;
        logic              is_pad;
    } in_t;

    typedef struct packed {
        logic [TILE_W-1:0] tile_out;
        logic              frame_end;
    } out_t;

    typedef struct packed {
        logic emit;
        logic last;
        logic has_left;
        logic has_right;
        logic has_top;
        logic has_bottom;
    } ctl_t;

endpackage

>>> rtl/core/twol_row_ram.sv
`timescale 1ns / 1ps
module twol_row_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 16
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [0:DEPTH-1];
    logic [DW-1:0] rd_data_reg;

    // A read that meets a write to the same entry returns the new data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/twol_seq.sv
`timescale 1ns / 1ps
module twol_seq #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64,
    parameter int CW         = 7
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic [twol_pkg::WIDTH_W-1:0]  map_width,
    input  logic [twol_pkg::HEIGHT_W-1:0] map_height,
    output logic [CW-1:0]                 rd_addr,
    output logic [CW-1:0]                 addr_reg,
    output twol_pkg::ctl_t                ctl_reg
);

    localparam int WB  = $clog2(MAX_WIDTH + 1);
    localparam int WCW = (WB > twol_pkg::WIDTH_W) ? WB : twol_pkg::WIDTH_W;
    localparam int RW  = $clog2(MAX_HEIGHT + 3);
    localparam int HCW = (RW > twol_pkg::HEIGHT_W) ? RW : twol_pkg::HEIGHT_W;

    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [WCW-1:0] w_ext, w, c_ext, c1, c, cn;
    logic [HCW-1:0] h_ext, h, r_ext, r1, r;
    logic           wrap, restart, sel_a;
    twol_pkg::ctl_t ctl;

    always_comb begin
        w_ext = WCW'(map_width);
        h_ext = HCW'(map_height);
        if (w_ext < WCW'(3)) begin
            w = WCW'(3);
        end else if (w_ext > WCW'(MAX_WIDTH)) begin
            w = WCW'(MAX_WIDTH);
        end else begin
            w = w_ext;
        end
        if (h_ext < HCW'(3)) begin
            h = HCW'(3);
        end else if (h_ext > HCW'(MAX_HEIGHT)) begin
            h = HCW'(MAX_HEIGHT);
        end else begin
            h = h_ext;
        end
    end

    always_comb begin
        c_ext   = WCW'(col_reg);
        r_ext   = HCW'(row_reg);
        wrap    = (c_ext >= w);
        c1      = wrap ? '0 : c_ext;
        r1      = wrap ? (r_ext + HCW'(1)) : r_ext;
        restart = (r1 > (h + HCW'(1))) || ((r1 == (h + HCW'(1))) && (c1 != '0));
        c       = restart ? '0 : c1;
        r       = restart ? '0 : r1;
        sel_a   = (c == '0);

        // Column zero finishes the last tile of the row two rows up.
        ctl.emit       = sel_a ? (r >= HCW'(2)) : (r >= HCW'(1));
        ctl.last       = sel_a && (r == (h + HCW'(1)));
        ctl.has_left   = sel_a ? 1'b1 : (c >= WCW'(2));
        ctl.has_right  = !sel_a;
        ctl.has_top    = sel_a ? (r != HCW'(2)) : (r != HCW'(1));
        ctl.has_bottom = sel_a ? (r <= h) : (r < h);

        cn = c + WCW'(1);
        if (ctl.last) begin
            col_next = '0;
            row_next = '0;
        end else if (cn >= w) begin
            col_next = '0;
            row_next = RW'(r + HCW'(1));
        end else begin
            col_next = CW'(cn);
            row_next = RW'(r);
        end
        rd_addr = CW'(c);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            ctl_reg <= '0;
        end else if (adv) begin
            col_reg <= col_next;
            row_reg <= row_next;
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            addr_reg <= rd_addr;
        end
    end

endmodule

>>> rtl/core/twol_window.sv
`timescale 1ns / 1ps
module twol_window #(
    parameter int TILE_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  twol_pkg::ctl_t       ctl,
    input  logic [TILE_BITS-1:0] tile,
    input  logic [TILE_BITS-1:0] up,
    input  logic [TILE_BITS-1:0] mid,
    input  logic [TILE_BITS-1:0] void_code,
    input  logic [TILE_BITS-1:0] floor_code,
    input  logic [TILE_BITS-1:0] wall_code,
    output logic [TILE_BITS-1:0] res
);

    logic [TILE_BITS-1:0] left_reg [0:2];
    logic [TILE_BITS-1:0] cen_reg  [0:2];
    logic [TILE_BITS-1:0] new_col  [0:2];
    logic [2:0]           row_en;
    logic                 hit;

    always_comb begin
        new_col[0] = up;
        new_col[1] = mid;
        new_col[2] = tile;
        row_en     = {ctl.has_bottom, 1'b1, ctl.has_top};
        hit        = 1'b0;
        for (int j = 0; j < 3; j++) begin
            hit = hit | (row_en[j] && (cen_reg[j] == floor_code));
            hit = hit | (row_en[j] && ctl.has_left && (left_reg[j] == floor_code));
            hit = hit | (row_en[j] && ctl.has_right && (new_col[j] == floor_code));
        end
        res = ((cen_reg[1] == void_code) && hit) ? wall_code : cen_reg[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < 3; j++) begin
                left_reg[j] <= '0;
                cen_reg[j]  <= '0;
            end
        end else if (fire) begin
            for (int j = 0; j < 3; j++) begin
                left_reg[j] <= cen_reg[j];
                cen_reg[j]  <= new_col[j];
            end
        end
    end

endmodule

>>> rtl/core/tile_wall_outline_3x3.sv
`timescale 1ns / 1ps
// Streaming 3x3 wall outline: a tile equal to void_code becomes wall_code when any tile of its
// 3x3 neighborhood inside the map equals floor_code. Tiles enter in raster order at one transaction per
// clock while s_ready is high, and each produces at most one result, for the map position map_width+1
// tiles earlier; after the last tile send map_width+1 pad transactions to flush. The two rows above the
// current column sit in a single row RAM that is read when a tile is taken and written back when it
// leaves the first stage, so with m_ready high the block sustains one tile per cycle, and a result
// enters the output register as the tile that completes it leaves the first stage. Sizes are clamped
// to 3..MAX_WIDTH and 3..MAX_HEIGHT; the user must write configuration while idle, the block does not check.
module tile_wall_outline_3x3 #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64,
    parameter int TILE_BITS  = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [twol_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [twol_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  twol_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output twol_pkg::out_t                  m_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [twol_pkg::WIDTH_W-1:0]  map_width_reg;
    logic [twol_pkg::HEIGHT_W-1:0] map_height_reg;
    logic [twol_pkg::TILE_W-1:0]   void_code_reg, floor_code_reg, wall_code_reg;

    logic                 s1_valid_reg, s1_valid_next;
    logic [TILE_BITS-1:0] s1_tile_reg, tile_in_m;
    logic                 m_valid_reg, m_valid_next;
    twol_pkg::out_t       m_data_reg;
    logic                 accept, out_free, s1_fire;

    logic [CW-1:0]          rd_addr, wr_addr;
    twol_pkg::ctl_t         s1_ctl;
    logic [2*TILE_BITS-1:0] rd_data;
    logic [TILE_BITS-1:0]   void_m, floor_m, wall_m, res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg  <= 8'd80;
            map_height_reg <= 7'd24;
            void_code_reg  <= 8'd0;
            floor_code_reg <= 8'd1;
            wall_code_reg  <= 8'd2;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                twol_pkg::REG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                twol_pkg::REG_MAP_HEIGHT: map_height_reg <= cfg_data[twol_pkg::HEIGHT_W-1:0];
                twol_pkg::REG_VOID_CODE:  void_code_reg  <= cfg_data;
                twol_pkg::REG_FLOOR_CODE: floor_code_reg <= cfg_data;
                twol_pkg::REG_WALL_CODE:  wall_code_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign void_m    = void_code_reg[TILE_BITS-1:0];
    assign floor_m   = floor_code_reg[TILE_BITS-1:0];
    assign wall_m    = wall_code_reg[TILE_BITS-1:0];
    assign tile_in_m = s_data.is_pad ? void_m : s_data.tile_in[TILE_BITS-1:0];

    assign out_free = !m_valid_reg || m_ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || s1_fire;
    assign accept   = s_valid && s_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s1_fire) begin
            m_valid_next = s1_ctl.emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_tile_reg <= tile_in_m;
        end
        if (s1_fire) begin
            m_data_reg.tile_out  <= twol_pkg::TILE_W'(res);
            m_data_reg.frame_end <= s1_ctl.last;
        end
    end

    twol_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (accept),
        .map_width  (map_width_reg),
        .map_height (map_height_reg),
        .rd_addr    (rd_addr),
        .addr_reg   (wr_addr),
        .ctl_reg    (s1_ctl)
    );

    // Each entry holds the tile two rows up above the tile one row up.
    twol_row_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (2*TILE_BITS)
    ) u_row_ram (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (s1_fire),
        .wr_addr (wr_addr),
        .wr_data ({rd_data[TILE_BITS-1:0], s1_tile_reg})
    );

    twol_window #(
        .TILE_BITS (TILE_BITS)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (s1_fire),
        .ctl        (s1_ctl),
        .tile       (s1_tile_reg),
        .up         (rd_data[2*TILE_BITS-1:TILE_BITS]),
        .mid        (rd_data[TILE_BITS-1:0]),
        .void_code  (void_m),
        .floor_code (floor_m),
        .wall_code  (wall_m),
        .res        (res)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_last_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && s1_ctl.last) |=> (m_valid && m_data.frame_end))
        else $error("Frame end transaction did not reach the output register.");

    a_silent_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && !s1_ctl.emit) |=> !m_valid)
        else $error("A transaction without a result produced output.");

    a_last_is_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_ctl.last) |-> (s1_ctl.emit && !s1_ctl.has_right))
        else $error("Frame end marked on a tile that is not the last of its row.");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid && !m_ready) |-> !s_ready)
        else $error("Input taken while the pipeline is stalled.");
`endif

endmodule
